FILE: rtl/gdad_pkg.sv
// package for the gregorian date add days block: types, constants and calendar functions
package gdad_pkg;

  localparam int unsigned MaxYearDefault = 9999;

  // widths fixed by the item fields
  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned AddW   = 20;
  // remainder: 31 + 335 + (2^20 - 1) fits in 21 bits
  localparam int unsigned RemW   = 21;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 24;

  localparam logic [YearW-1:0]  Cycle400  = YearW'(400);
  localparam logic [YearW-1:0]  Last400   = YearW'(399);
  localparam logic [MonthW-1:0] January   = MonthW'(1);
  localparam logic [MonthW-1:0] February  = MonthW'(2);
  localparam logic [MonthW-1:0] December  = MonthW'(12);
  localparam logic [DayW-1:0]   LastDay   = DayW'(31);

  typedef enum logic [2:0] {
    StIdle,
    StMod,
    StOrd,
    StYear,
    StMon,
    StOut
  } state_e;

  // leap test from the year taken modulo 400
  function automatic logic leap_mod400(logic [YearW-1:0] r);
    logic l;
    l = (r[1:0] == 2'b00) && (r != YearW'(100)) && (r != YearW'(200)) &&
        (r != YearW'(300));
    return l;
  endfunction

  function automatic logic [DayW-1:0] month_days(logic [MonthW-1:0] m, logic leap);
    logic [DayW-1:0] d;
    case (m)
      4'd2:                          d = leap ? DayW'(29) : DayW'(28);
      4'd4, 4'd6, 4'd9, 4'd11:       d = DayW'(30);
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
      4'd10, 4'd12:                  d = DayW'(31);
      default:                       d = '0;
    endcase
    return d;
  endfunction

  function automatic logic [8:0] year_days(logic leap);
    logic [8:0] d;
    d = leap ? 9'd366 : 9'd365;
    return d;
  endfunction

endpackage

FILE: rtl/gregorian_date_add_days.sv
// gregorian date add days: top level with shared add/subtract unit and sequencer
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid_i/tready_o    start date and day count (tdata)
//  m_axis    out  m_axis_tvalid_o/tready_i    result date (tdata), overflow (tuser)
//
// a request walks the states idle, mod (strip whole 400 year cycles off the start year),
//   ord (add the months before the start month, then the day count), year, month and out;
//   a start year past the maximum skips to the output
// s_axis_tready_o is high only while the sequencer is idle
// the result is held in registers until m_axis_tready_i takes it
// rst_ni is asynchronous and active low; it returns the sequencer to idle
module gregorian_date_add_days #(
  parameter int unsigned MAX_YEAR = gdad_pkg::MaxYearDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [13:0] start_year, [17:14] start_month, [22:18] start_day,
  // [42:23] days_to_add, [47:43] zero
  input  logic [gdad_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [13:0] result_year, [17:14] result_month, [22:18] result_day, [23] zero
  output logic [gdad_pkg::OutDataW-1:0] m_axis_tdata_o,
  // [0] year_overflow
  output logic                          m_axis_tuser_o
);

  localparam int unsigned YW0 = $clog2(MAX_YEAR + 2);
  // internal year wide enough for the start year field and for the maximum
  localparam int unsigned YW  = (YW0 > gdad_pkg::YearW) ? YW0 : gdad_pkg::YearW;
  localparam int unsigned RW  = gdad_pkg::RemW;
  localparam logic [YW-1:0] MaxYear = YW'(MAX_YEAR);

  gdad_pkg::state_e state_q, state_d;

  logic [YW-1:0]                   year_q, year_d;
  logic [gdad_pkg::YearW-1:0]      y400_q, y400_d;   // year modulo 400
  logic [gdad_pkg::MonthW-1:0]     m_q, m_d;         // month walker
  logic [gdad_pkg::MonthW-1:0]     mlim_q, mlim_d;   // clamped start month
  logic [RW-1:0]                   rem_q, rem_d;     // ordinal day remainder
  logic [gdad_pkg::AddW-1:0]       add_q, add_d;
  logic                            ovf_q, ovf_d;

  // unpacked request fields
  logic [gdad_pkg::YearW-1:0]  in_year;
  logic [gdad_pkg::MonthW-1:0] in_month, in_month_c;
  logic [gdad_pkg::DayW-1:0]   in_day, in_day_c;
  logic [gdad_pkg::AddW-1:0]   in_add;

  assign in_year  = s_axis_tdata_i[13:0];
  assign in_month = s_axis_tdata_i[17:14];
  assign in_day   = s_axis_tdata_i[22:18];
  assign in_add   = s_axis_tdata_i[42:23];

  // out of range months clamp to january or december, day zero reads as day one
  always_comb begin
    if (in_month == '0) begin
      in_month_c = gdad_pkg::January;
    end else if (in_month > gdad_pkg::December) begin
      in_month_c = gdad_pkg::December;
    end else begin
      in_month_c = in_month;
    end
    in_day_c = (in_day == '0) ? gdad_pkg::DayW'(1) : in_day;
  end

  // calendar of the current year
  logic                        leap;
  logic [gdad_pkg::DayW-1:0]   mdays;
  logic [8:0]                  ydays;

  assign leap  = gdad_pkg::leap_mod400(y400_q);
  assign mdays = gdad_pkg::month_days(m_q, leap);
  assign ydays = gdad_pkg::year_days(leap);

  // shared add/subtract unit: res = a + b, or a - b with carry meaning a >= b
  logic [RW-1:0] u_a, u_b;
  logic          u_sub;
  logic [RW:0]   u_res;
  logic          u_ge, u_gt;

  assign u_res = {1'b0, u_a} + {1'b0, (u_sub ? ~u_b : u_b)} + {{RW{1'b0}}, u_sub};
  assign u_ge  = u_res[RW];
  assign u_gt  = u_ge && (u_res[RW-1:0] != '0);

  // operand selection per sequencer step
  always_comb begin
    u_a   = rem_q;
    u_b   = '0;
    u_sub = 1'b1;
    unique case (state_q)
      gdad_pkg::StMod: begin
        // strip whole 400 year cycles off the start year
        u_a = RW'(y400_q);
        u_b = RW'(gdad_pkg::Cycle400);
      end
      gdad_pkg::StOrd: begin
        // add month lengths before the start month, then the day count
        u_sub = 1'b0;
        u_b   = (m_q < mlim_q) ? RW'(mdays) : RW'(add_q);
      end
      gdad_pkg::StYear: begin
        u_b = RW'(ydays);
      end
      gdad_pkg::StMon: begin
        u_b = RW'(mdays);
      end
      default: begin
        u_a = rem_q;
      end
    endcase
  end

  // sequencer: next state and register updates
  always_comb begin
    state_d = state_q;
    year_d  = year_q;
    y400_d  = y400_q;
    m_d     = m_q;
    mlim_d  = mlim_q;
    rem_d   = rem_q;
    add_d   = add_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      gdad_pkg::StIdle: begin
        if (s_axis_tvalid_i) begin
          year_d = YW'(in_year);
          y400_d = in_year;
          m_d    = gdad_pkg::January;
          mlim_d = in_month_c;
          rem_d  = RW'(in_day_c);
          add_d  = in_add;
          if (YW'(in_year) > MaxYear) begin
            // start year already beyond range: saturate straight away
            ovf_d   = 1'b1;
            year_d  = MaxYear;
            m_d     = gdad_pkg::December;
            rem_d   = RW'(gdad_pkg::LastDay);
            state_d = gdad_pkg::StOut;
          end else begin
            ovf_d   = 1'b0;
            state_d = gdad_pkg::StMod;
          end
        end
      end
      gdad_pkg::StMod: begin
        if (u_ge) begin
          y400_d = u_res[gdad_pkg::YearW-1:0];
        end else begin
          state_d = gdad_pkg::StOrd;
        end
      end
      gdad_pkg::StOrd: begin
        rem_d = u_res[RW-1:0];
        if (m_q < mlim_q) begin
          m_d = m_q + gdad_pkg::MonthW'(1);
        end else begin
          m_d     = gdad_pkg::January;
          state_d = gdad_pkg::StYear;
        end
      end
      gdad_pkg::StYear: begin
        if (u_gt) begin
          if (year_q >= MaxYear) begin
            ovf_d   = 1'b1;
            year_d  = MaxYear;
            m_d     = gdad_pkg::December;
            rem_d   = RW'(gdad_pkg::LastDay);
            state_d = gdad_pkg::StOut;
          end else begin
            rem_d  = u_res[RW-1:0];
            year_d = year_q + YW'(1);
            y400_d = (y400_q == gdad_pkg::Last400) ? '0
                                                   : y400_q + gdad_pkg::YearW'(1);
          end
        end else begin
          state_d = gdad_pkg::StMon;
        end
      end
      gdad_pkg::StMon: begin
        if (u_gt && (m_q < gdad_pkg::December)) begin
          rem_d = u_res[RW-1:0];
          m_d   = m_q + gdad_pkg::MonthW'(1);
        end else begin
          state_d = gdad_pkg::StOut;
        end
      end
      gdad_pkg::StOut: begin
        if (m_axis_tready_i) begin
          state_d = gdad_pkg::StIdle;
        end
      end
      default: begin
        state_d = gdad_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gdad_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    year_q <= year_d;
    y400_q <= y400_d;
    m_q    <= m_d;
    mlim_q <= mlim_d;
    rem_q  <= rem_d;
    add_q  <= add_d;
    ovf_q  <= ovf_d;
  end

  assign s_axis_tready_o = (state_q == gdad_pkg::StIdle);
  assign m_axis_tvalid_o = (state_q == gdad_pkg::StOut);
  assign m_axis_tdata_o  = {1'b0, rem_q[gdad_pkg::DayW-1:0], m_q,
                            year_q[gdad_pkg::YearW-1:0]};
  assign m_axis_tuser_o  = ovf_q;

  // assertions
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("accepted a request while busy");

  a_mod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gdad_pkg::StOrd || state_q == gdad_pkg::StYear ||
     state_q == gdad_pkg::StMon) |-> (y400_q < gdad_pkg::Cycle400))
    else $error("year modulo 400 out of range");

  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gdad_pkg::StOut) |-> (year_q <= MaxYear))
    else $error("result year beyond maximum");

  a_ovf_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (m_q == gdad_pkg::December && rem_q == RW'(gdad_pkg::LastDay)))
    else $error("overflow result not saturated");

  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (rem_q != '0 && rem_q <= RW'(gdad_pkg::LastDay) &&
                         m_q != '0 && m_q <= gdad_pkg::December))
    else $error("result date out of range");

endmodule
